// File: design/csau_pkg.sv
// package with transfer types and constants for the checked scaled arithmetic unit
package csau_pkg;

    typedef enum logic [1:0] {
        OP_MUL_ADD = 2'd0,
        OP_DIV_INT = 2'd1,
        OP_MUL_DIV = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] n;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        max_ans;
        logic [16:0]        d;
        logic               clear_error;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic signed [31:0] remainder;
        logic               this_error;
        logic               sticky_error;
    } rsp_t;

    // divider dividend and quotient width, one bit per step
    localparam int DIV_W = 34;
    localparam logic [5:0] DIV_STEPS = 6'd34;
    localparam int HALF_BITS = 15;
    localparam logic [31:0] MAX_N_MUL_DIV = 32'd65536;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

endpackage

// File: design/checked_scaled_arithmetic_unit_top.sv
// top level of the checked scaled arithmetic unit: sequencer, shared multiplier and divider
//
// channel   signals              direction  transfer when
// command   start, busy, req     in         rising edge with start high and busy low
// result    done, rsp            out        rising edge ending the single cycle done is high
//
// the restoring divider gives one quotient bit a cycle over 34 bits and is used once for op 1
// and twice for ops 0 and 2; op 3 and operands rejected up front do not use the divider
// reset clears the sequencer, the sticky error flag and the kept remainder
// the result is shown for one cycle with done; the receiver cannot stall it
// busy is high from the cycle after a command transfer until done, but stays low for commands done without the divider
module checked_scaled_arithmetic_unit_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  csau_pkg::req_t req,
    output logic           done,
    output csau_pkg::rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_DIV
    } state_t;

    state_t state_reg, state_next;

    // latched command
    logic [1:0]         op_reg, op_next;
    logic [31:0]        n_reg, n_next;
    logic [31:0]        x_reg, x_next;
    logic [31:0]        y_reg, y_next;
    logic [31:0]        mag_reg, mag_next;
    logic [16:0]        d_reg, d_next;

    // op 0 bound check operands
    logic signed [35:0] xa_reg, xa_next;
    logic signed [35:0] num2_reg, num2_next;
    logic               num_neg_reg, num_neg_next;
    logic               ok1_reg, ok1_next;

    // op 2 intermediate values
    logic [31:0]        t_reg, t_next;
    logic [31:0]        prod_reg, prod_next;
    logic               ovf_reg, ovf_next;
    logic               pass_reg, pass_next;

    // shared restoring divider
    logic [31:0]        div_rem_reg, div_rem_next;
    logic [33:0]        div_quo_reg, div_quo_next;
    logic [31:0]        div_den_reg, div_den_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;

    // outputs and kept state
    logic [31:0]        result_reg, result_next;
    logic               this_err_reg, this_err_next;
    logic               sticky_reg, sticky_next;
    logic [31:0]        last_rem_reg, last_rem_next;
    logic               done_reg, done_next;

    // shared multiplier
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;

    // divider step
    logic [32:0]        div_shift;
    logic [33:0]        div_diff;
    logic               div_ge;
    logic [31:0]        fin_rem;
    logic [33:0]        fin_quo;

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        mul_a = x_reg;
        mul_b = n_reg;
        if (state_reg == S_MUL1)
        begin
            mul_a = {15'd0, mag_reg[31:15]};
        end
        else if (op_reg == csau_pkg::OP_MUL_DIV)
        begin
            mul_a = {17'd0, mag_reg[14:0]};
        end
    end

    assign div_shift = {div_rem_reg, div_quo_reg[33]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, div_den_reg};
    assign div_ge    = ~div_diff[33];
    assign fin_rem   = div_ge ? div_diff[31:0] : div_shift[31:0];
    assign fin_quo   = {div_quo_reg[32:0], div_ge};

    always_comb
    begin
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        logic signed [35:0] ms;
        logic signed [35:0] num1;
        logic signed [35:0] numb;
        logic signed [35:0] qs;
        logic [31:0]        na;
        logic [31:0]        xm;
        logic [31:0]        uval;
        logic [33:0]        u;
        logic               sticky_base;
        logic               ok;

        state_next    = state_reg;
        op_next       = op_reg;
        n_next        = n_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        mag_next      = mag_reg;
        d_next        = d_reg;
        xa_next       = xa_reg;
        num2_next     = num2_reg;
        num_neg_next  = num_neg_reg;
        ok1_next      = ok1_reg;
        t_next        = t_reg;
        prod_next     = prod_reg;
        ovf_next      = ovf_reg;
        pass_next     = pass_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;
        div_den_next  = div_den_reg;
        div_cnt_next  = div_cnt_reg;
        result_next   = result_reg;
        this_err_next = this_err_reg;
        sticky_next   = sticky_reg;
        last_rem_next = last_rem_reg;
        done_next     = 1'b0;

        xs   = 36'(req.x);
        ys   = 36'(req.y);
        ms   = 36'($signed({1'b0, req.max_ans}));
        num1 = ms - ys;
        na   = req.n[31] ? (32'd0 - req.n) : req.n;
        xm   = req.x[31] ? (32'd0 - req.x) : req.x;
        qs   = num_neg_reg ? (36'sd0 - $signed({2'b00, fin_quo})) : $signed({2'b00, fin_quo});
        u    = mul_p[33:0] + 34'(t_reg[31:15]);
        sticky_base = req.clear_error ? 1'b0 : sticky_reg;
        ok   = 1'b0;
        uval = 32'd0;
        numb = 36'sd0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = req.op;
                    n_next       = req.n;
                    x_next       = req.x;
                    y_next       = req.y;
                    d_next       = req.d;
                    mag_next     = xm;
                    sticky_next  = sticky_base;
                    pass_next    = 1'b0;
                    div_rem_next = 32'd0;
                    div_den_next = na;
                    div_cnt_next = csau_pkg::DIV_STEPS;
                    case (req.op)
                        csau_pkg::OP_MUL_ADD:
                        begin
                            xa_next      = req.n[31] ? (36'sd0 - xs) : xs;
                            num2_next    = ms + ys;
                            num_neg_next = num1[35];
                            div_quo_next = num1[35] ? 34'(36'sd0 - num1) : num1[33:0];
                            if (req.n == 32'sd0)
                            begin
                                result_next   = req.y;
                                this_err_next = 1'b0;
                                done_next     = 1'b1;
                            end
                            else
                            begin
                                state_next = S_MUL0;
                            end
                        end
                        csau_pkg::OP_DIV_INT:
                        begin
                            div_quo_next = {2'b00, xm};
                            if (req.n == 32'sd0)
                            begin
                                result_next   = 32'd0;
                                last_rem_next = req.x;
                                this_err_next = 1'b1;
                                sticky_next   = 1'b1;
                                done_next     = 1'b1;
                            end
                            else if (req.x == csau_pkg::INT_MIN && req.n == -32'sd1)
                            begin
                                result_next   = csau_pkg::INT_MAX;
                                last_rem_next = 32'd0;
                                this_err_next = 1'b1;
                                sticky_next   = 1'b1;
                                done_next     = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        csau_pkg::OP_MUL_DIV:
                        begin
                            if (req.d == 17'd0 || req.n[31]
                                || req.n > csau_pkg::MAX_N_MUL_DIV)
                            begin
                                result_next   = 32'd0;
                                this_err_next = 1'b1;
                                sticky_next   = 1'b1;
                                done_next     = 1'b1;
                            end
                            else
                            begin
                                state_next = S_MUL0;
                            end
                        end
                        default:
                        begin
                            result_next   = 32'd0;
                            this_err_next = 1'b0;
                            done_next     = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL0:
            begin
                prod_next = mul_p[31:0];
                t_next    = mul_p[31:0];
                if (op_reg == csau_pkg::OP_MUL_DIV)
                begin
                    state_next = S_MUL1;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_MUL1:
            begin
                // u = (a div 2^15) * n + (t div 2^15), kept for the overflow case
                prod_next    = u[31:0];
                div_quo_next = u;
                div_rem_next = 32'd0;
                div_den_next = {15'd0, d_reg};
                div_cnt_next = csau_pkg::DIV_STEPS;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                div_rem_next = fin_rem;
                div_quo_next = fin_quo;
                div_cnt_next = div_cnt_reg - 6'd1;
                if (div_cnt_reg == 6'd1)
                begin
                    case (op_reg)
                        csau_pkg::OP_MUL_ADD:
                        begin
                            if (!pass_reg)
                            begin
                                ok1_next     = xa_reg <= qs;
                                numb         = num2_reg;
                                num_neg_next = numb[35];
                                div_quo_next = numb[35] ? 34'(36'sd0 - numb) : numb[33:0];
                                div_rem_next = 32'd0;
                                div_cnt_next = csau_pkg::DIV_STEPS;
                                pass_next    = 1'b1;
                            end
                            else
                            begin
                                ok            = ok1_reg && ((36'sd0 - xa_reg) <= qs);
                                result_next   = ok ? (prod_reg + y_reg) : 32'd0;
                                this_err_next = ~ok;
                                sticky_next   = sticky_reg | ~ok;
                                done_next     = 1'b1;
                                state_next    = S_IDLE;
                            end
                        end
                        csau_pkg::OP_DIV_INT:
                        begin
                            result_next   = (x_reg[31] ^ n_reg[31])
                                            ? (32'd0 - fin_quo[31:0]) : fin_quo[31:0];
                            last_rem_next = x_reg[31] ? (32'd0 - fin_rem) : fin_rem;
                            this_err_next = 1'b0;
                            done_next     = 1'b1;
                            state_next    = S_IDLE;
                        end
                        csau_pkg::OP_MUL_DIV:
                        begin
                            if (!pass_reg)
                            begin
                                // quotient of u by d must stay below 2^15
                                ovf_next = |fin_quo[33:csau_pkg::HALF_BITS];
                                if (~|fin_quo[33:csau_pkg::HALF_BITS])
                                begin
                                    prod_next = {fin_quo[16:0], 15'd0};
                                end
                                div_quo_next = {2'b00, fin_rem[16:0], t_reg[14:0]};
                                div_rem_next = 32'd0;
                                div_cnt_next = csau_pkg::DIV_STEPS;
                                pass_next    = 1'b1;
                            end
                            else
                            begin
                                uval          = ovf_reg ? prod_reg : (prod_reg + fin_quo[31:0]);
                                result_next   = x_reg[31] ? (32'd0 - uval) : uval;
                                last_rem_next = x_reg[31] ? (32'd0 - fin_rem) : fin_rem;
                                this_err_next = ovf_reg;
                                sticky_next   = sticky_reg | ovf_reg;
                                done_next     = 1'b1;
                                state_next    = S_IDLE;
                            end
                        end
                        default:
                        begin
                            result_next   = 32'd0;
                            this_err_next = 1'b0;
                            done_next     = 1'b1;
                            state_next    = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sticky_reg   <= 1'b0;
            last_rem_reg <= 32'd0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sticky_reg   <= sticky_next;
            last_rem_reg <= last_rem_next;
            done_reg     <= done_next;
        end
    end

    // datapath registers, not reset; the command is loaded into them at each command transfer
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        n_reg        <= n_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        mag_reg      <= mag_next;
        d_reg        <= d_next;
        xa_reg       <= xa_next;
        num2_reg     <= num2_next;
        num_neg_reg  <= num_neg_next;
        ok1_reg      <= ok1_next;
        t_reg        <= t_next;
        prod_reg     <= prod_next;
        ovf_reg      <= ovf_next;
        pass_reg     <= pass_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_den_reg  <= div_den_next;
        div_cnt_reg  <= div_cnt_next;
        result_reg   <= result_next;
        this_err_reg <= this_err_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign rsp.result       = result_reg;
    assign rsp.remainder    = last_rem_reg;
    assign rsp.this_error   = this_err_reg;
    assign rsp.sticky_error = sticky_reg;

endmodule

// File: design/csau_checker.sv
// port checker for the checked scaled arithmetic unit and its bind
module csau_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input csau_pkg::rsp_t rsp
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_start_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("command transfer left no trace");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.this_error) |-> rsp.sticky_error)
        else $error("error not held in sticky flag");

endmodule

bind checked_scaled_arithmetic_unit_top csau_checker u_csau_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
